// ===== hw/rtl/sdpo_pkg.sv =====
// ============================================================================
// sdpo_pkg
// Shared constants, types and the cosine table of the shaded disk overlay.
// ============================================================================
package sdpo_pkg;

    localparam int MAX_DIMENSION = 4096;
    localparam int DIM_W         = $clog2(MAX_DIMENSION) + 1;
    localparam int CFG_W         = 13;
    localparam int PIX_W         = 12;
    localparam int CH_W          = 8;
    localparam int FRAME_W       = 9;
    localparam int COS_W         = 16;
    localparam int COS_ENTRIES   = 2 ** FRAME_W;

    localparam int R_W           = 9;
    localparam int CX_W          = 12;
    localparam int SX_W          = 13;
    localparam int POS_W         = 14;
    localparam int H38_W         = 11;
    localparam int H34_W         = 12;
    localparam int T_W           = 12;
    localparam int PROD_W        = COS_W + H38_W;
    localparam int DIV10_MUL     = 52429;
    localparam int DIV10_W       = 16;
    localparam int DIV10_SHIFT   = 19;
    localparam int DIV_PROD_W    = DIM_W + DIV10_W;
    localparam int COS_FRAC      = 15;

    localparam int ROOT_W        = 13;
    localparam int RAD_W         = 2 * ROOT_W;

    localparam int GEOM_LAT      = 6;
    localparam int OFFSET_LAT    = 3;
    localparam int ISQRT_LAT     = ROOT_W;
    localparam int SIDE_LAT      = OFFSET_LAT + ISQRT_LAT;
    localparam int PIPE_LAT      = GEOM_LAT + SIDE_LAT + 1;

    localparam int CFG_IDX_W     = 2;

    localparam logic [63:0] TWO_PI_Q48  = 64'h6487ED5110B46;
    localparam logic [63:0] PI_Q48      = 64'h3243F6A8885A3;
    localparam logic [63:0] HALF_PI_Q48 = 64'h1921FB54442D1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_FRAME_NUMBER = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [DIM_W-1:0]        wc;
        logic [DIM_W-1:0]        hc;
        logic [R_W-1:0]          r;
        logic [CX_W-1:0]         cx;
        logic [SX_W-1:0]         sx;
        logic signed [POS_W-1:0] cy;
        logic signed [POS_W-1:0] sy;
    } geom_t;

    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
    } pix_t;

    typedef struct packed {
        logic             inframe;
        logic [R_W-1:0]   r;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
    } side_t;

    typedef logic signed [COS_W-1:0] cos_rom_t [COS_ENTRIES];

    // cos(n rad) in Q1.15 via range reduction and a 13-term series
    function automatic cos_rom_t build_cos_rom();
        cos_rom_t           rom;
        logic [63:0]        rem;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        q;
        logic signed [63:0] sum;
        logic               neg;
        for (int n = 0; n < COS_ENTRIES; n++)
        begin
            neg = 1'b0;
            rem = (64'(n) << 48) % TWO_PI_Q48;
            if (rem > PI_Q48)
            begin
                rem = TWO_PI_Q48 - rem;
            end
            if (rem > HALF_PI_Q48)
            begin
                rem = PI_Q48 - rem;
                neg = 1'b1;
            end
            x    = rem >> 18;
            x2   = (x * x) >> 30;
            term = 64'd1 << 30;
            sum  = $signed(term);
            for (int k = 1; k <= 12; k++)
            begin
                term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
                if ((k % 2) == 1)
                begin
                    sum = sum - $signed(term);
                end
                else
                begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0)
            begin
                sum = '0;
            end
            q = ($unsigned(sum) + (64'd1 << 14)) >> 15;
            if (q > 64'd32767)
            begin
                q = 64'd32767;
            end
            rom[n] = neg ? -$signed(COS_W'(q)) : $signed(COS_W'(q));
        end
        return rom;
    endfunction

    localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

// ===== hw/rtl/shaded_disk_pixel_overlay.sv =====
// ============================================================================
// shaded_disk_pixel_overlay
// Pixel stream overlay that draws a shaded ball swinging with the frame.
// ============================================================================
// One pixel is taken on every clock (busy is low except for the first cycle
// out of reset). Each pixel comes back, in order, after its start transfer,
// with strobe high for one cycle; there is no back-pressure, so the receiver
// must take every result on the cycle it appears. The depth is set by the
// six-stage geometry pipeline, the three-stage offset/square stage and the
// two 13-stage floor square root pipelines. Write configuration only while
// no pixel is in flight.
module shaded_disk_pixel_overlay
    import sdpo_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [PIX_W-1:0]     pix_x,
    input  logic [PIX_W-1:0]     pix_y,
    input  logic [CH_W-1:0]      in_red,
    input  logic [CH_W-1:0]      in_green,
    input  logic [CH_W-1:0]      in_blue,
    output logic                 strobe,
    output logic [CH_W-1:0]      out_red,
    output logic [CH_W-1:0]      out_green,
    output logic [CH_W-1:0]      out_blue,
    output logic                 on_ball,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [CFG_W-1:0]   frame_width_reg;
    logic [CFG_W-1:0]   frame_height_reg;
    logic [FRAME_W-1:0] frame_number_reg;
    logic               busy_reg;
    logic               accept;

    pix_t               item_reg       [GEOM_LAT];
    logic               item_valid_reg [GEOM_LAT];
    side_t              side_reg       [SIDE_LAT];
    logic               side_valid_reg [SIDE_LAT];
    side_t              side_next;

    geom_t              geom;
    logic [RAD_W-1:0]   center_sq;
    logic [RAD_W-1:0]   spot_sq;
    logic [ROOT_W-1:0]  center_root;
    logic [ROOT_W-1:0]  spot_root;

    side_t              last;
    logic               hit;
    logic [CH_W-1:0]    shade;

    logic               strobe_reg;
    logic [CH_W-1:0]    out_red_reg, out_green_reg, out_blue_reg;
    logic               on_ball_reg;

    assign accept = start && !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= CFG_W'(640);
            frame_height_reg <= CFG_W'(480);
            frame_number_reg <= '0;
            busy_reg         <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
            if (cfg_write)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                    CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                    CFG_FRAME_NUMBER: frame_number_reg <= cfg_data[FRAME_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    sdpo_geom u_geom (
        .clk          (clk),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .frame_number (frame_number_reg),
        .geom         (geom)
    );

    // pixel delay line, aligned with the geometry stages
    always_ff @(posedge clk)
    begin
        item_reg[0] <= '{px: pix_x, py: pix_y, red: in_red, green: in_green, blue: in_blue};
        for (int i = 1; i < GEOM_LAT; i++)
        begin
            item_reg[i] <= item_reg[i-1];
        end
    end

    sdpo_offset u_offset (
        .clk       (clk),
        .geom      (geom),
        .px        (item_reg[GEOM_LAT-1].px),
        .py        (item_reg[GEOM_LAT-1].py),
        .center_sq (center_sq),
        .spot_sq   (spot_sq)
    );

    sdpo_isqrt u_center_sqrt (
        .clk      (clk),
        .radicand (center_sq),
        .root     (center_root)
    );

    sdpo_isqrt u_spot_sqrt (
        .clk      (clk),
        .radicand (spot_sq),
        .root     (spot_root)
    );

    assign side_next.inframe = ({1'b0, item_reg[GEOM_LAT-1].px} < geom.wc) &&
                               ({1'b0, item_reg[GEOM_LAT-1].py} < geom.hc);
    assign side_next.r       = geom.r;
    assign side_next.red     = item_reg[GEOM_LAT-1].red;
    assign side_next.green   = item_reg[GEOM_LAT-1].green;
    assign side_next.blue    = item_reg[GEOM_LAT-1].blue;

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_next;
        for (int i = 1; i < SIDE_LAT; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < GEOM_LAT; i++)
            begin
                item_valid_reg[i] <= 1'b0;
            end
            for (int i = 0; i < SIDE_LAT; i++)
            begin
                side_valid_reg[i] <= 1'b0;
            end
            strobe_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg[0] <= accept;
            for (int i = 1; i < GEOM_LAT; i++)
            begin
                item_valid_reg[i] <= item_valid_reg[i-1];
            end
            side_valid_reg[0] <= item_valid_reg[GEOM_LAT-1];
            for (int i = 1; i < SIDE_LAT; i++)
            begin
                side_valid_reg[i] <= side_valid_reg[i-1];
            end
            strobe_reg <= side_valid_reg[SIDE_LAT-1];
        end
    end

    assign last  = side_reg[SIDE_LAT-1];
    assign hit   = last.inframe && (center_root <= ROOT_W'(last.r));
    // 2r - distance, low bits only
    assign shade = {last.r[CH_W-2:0], 1'b0} - spot_root[CH_W-1:0];

    always_ff @(posedge clk)
    begin
        out_red_reg   <= hit ? shade : last.red;
        out_green_reg <= hit ? shade : last.green;
        out_blue_reg  <= hit ? shade : last.blue;
        on_ball_reg   <= hit;
    end

    assign busy      = busy_reg;
    assign strobe    = strobe_reg;
    assign out_red   = out_red_reg;
    assign out_green = out_green_reg;
    assign out_blue  = out_blue_reg;
    assign on_ball   = on_ball_reg;

    a_strobe_follows_start : assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(start && !busy, PIPE_LAT))
        else $error("result transfer without matching start");

    a_ball_is_grey : assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && on_ball) |-> (out_red == out_green && out_green == out_blue))
        else $error("ball pixel channels differ");

    a_outside_not_ball : assert property (@(posedge clk) disable iff (!rst_n)
        (side_valid_reg[SIDE_LAT-1] && !side_reg[SIDE_LAT-1].inframe) |=> !on_ball)
        else $error("out-of-frame pixel marked on ball");

endmodule

// ===== hw/rtl/sdpo_geom.sv =====
// ============================================================================
// sdpo_geom
// Six-stage ball geometry pipeline running from the configuration registers.
// ============================================================================
module sdpo_geom
    import sdpo_pkg::*;
(
    input  logic               clk,
    input  logic [CFG_W-1:0]   frame_width,
    input  logic [CFG_W-1:0]   frame_height,
    input  logic [FRAME_W-1:0] frame_number,
    output geom_t              geom
);

    // stage 1
    logic [DIM_W-1:0]        wc1_reg, hc1_reg, mn1_reg;
    logic [DIM_W-1:0]        wc1_next, hc1_next;
    logic signed [COS_W-1:0] cos1_reg;
    // stage 2
    logic [DIM_W-1:0]        wc2_reg, hc2_reg;
    logic [R_W-1:0]          r2_reg, r2_next;
    logic [CX_W-1:0]         cx2_reg;
    logic [H38_W-1:0]        h38_2_reg, h38_2_next;
    logic [H34_W-1:0]        h34_2_reg, h34_2_next;
    logic signed [COS_W-1:0] cos2_reg;
    logic [DIV_PROD_W-1:0]   div10_prod;
    // stage 3
    logic [DIM_W-1:0]        wc3_reg, hc3_reg;
    logic [R_W-1:0]          r3_reg;
    logic [CX_W-1:0]         cx3_reg;
    logic [H34_W-1:0]        h34_3_reg;
    logic [H38_W-1:0]        a3_reg;
    logic signed [COS_W-1:0] cos3_reg;
    // stage 4
    logic [DIM_W-1:0]        wc4_reg, hc4_reg;
    logic [R_W-1:0]          r4_reg;
    logic [CX_W-1:0]         cx4_reg;
    logic [H34_W-1:0]        h34_4_reg;
    logic signed [PROD_W:0]  prod_full;
    logic signed [PROD_W-1:0] m4_reg;
    // stage 5
    logic [DIM_W-1:0]        wc5_reg, hc5_reg;
    logic [R_W-1:0]          r5_reg;
    logic [CX_W-1:0]         cx5_reg;
    logic [SX_W-1:0]         sx5_reg, sx5_next;
    logic [H34_W-1:0]        h34_5_reg;
    logic signed [PROD_W-1:0] biased;
    logic signed [T_W-1:0]   t5_reg;
    // stage 6
    logic signed [POS_W-1:0] cy_next, sy_next;
    geom_t                   geom_reg;

    assign wc1_next = (frame_width > DIM_W'(MAX_DIMENSION)) ? DIM_W'(MAX_DIMENSION)
                                                            : frame_width;
    assign hc1_next = (frame_height > DIM_W'(MAX_DIMENSION)) ? DIM_W'(MAX_DIMENSION)
                                                             : frame_height;

    // min / 10 by reciprocal multiply, exact over the dimension range
    assign div10_prod = DIV_PROD_W'(mn1_reg) * DIV_PROD_W'(DIV10_MUL);
    assign r2_next    = div10_prod[DIV10_SHIFT +: R_W];
    assign h38_2_next = {1'b0, hc1_reg[DIM_W-1:3]} + {hc1_reg[DIM_W-1:3], 1'b0};
    assign h34_2_next = {1'b0, hc1_reg[DIM_W-1:2]} + {hc1_reg[DIM_W-1:2], 1'b0};

    assign prod_full = cos3_reg * $signed({1'b0, a3_reg});

    // cos * a truncated toward zero
    assign biased   = m4_reg + $signed({{(PROD_W-COS_FRAC){1'b0}}, {COS_FRAC{m4_reg[PROD_W-1]}}});
    assign sx5_next = SX_W'(cx4_reg) + SX_W'(r4_reg[R_W-1:1]);

    assign cy_next = $signed({2'b00, h34_5_reg}) - $signed({{(POS_W-T_W){t5_reg[T_W-1]}}, t5_reg});
    assign sy_next = cy_next - $signed({{(POS_W-R_W+1){1'b0}}, r5_reg[R_W-1:1]});

    always_ff @(posedge clk)
    begin
        wc1_reg   <= wc1_next;
        hc1_reg   <= hc1_next;
        mn1_reg   <= (wc1_next < hc1_next) ? wc1_next : hc1_next;
        cos1_reg  <= COS_ROM[frame_number];

        wc2_reg   <= wc1_reg;
        hc2_reg   <= hc1_reg;
        r2_reg    <= r2_next;
        cx2_reg   <= wc1_reg[DIM_W-1:1];
        h38_2_reg <= h38_2_next;
        h34_2_reg <= h34_2_next;
        cos2_reg  <= cos1_reg;

        wc3_reg   <= wc2_reg;
        hc3_reg   <= hc2_reg;
        r3_reg    <= r2_reg;
        cx3_reg   <= cx2_reg;
        h34_3_reg <= h34_2_reg;
        a3_reg    <= h38_2_reg - H38_W'(r2_reg);
        cos3_reg  <= cos2_reg;

        wc4_reg   <= wc3_reg;
        hc4_reg   <= hc3_reg;
        r4_reg    <= r3_reg;
        cx4_reg   <= cx3_reg;
        h34_4_reg <= h34_3_reg;
        m4_reg    <= prod_full[PROD_W-1:0];

        wc5_reg   <= wc4_reg;
        hc5_reg   <= hc4_reg;
        r5_reg    <= r4_reg;
        cx5_reg   <= cx4_reg;
        sx5_reg   <= sx5_next;
        h34_5_reg <= h34_4_reg;
        t5_reg    <= biased[PROD_W-1:COS_FRAC];

        geom_reg.wc <= wc5_reg;
        geom_reg.hc <= hc5_reg;
        geom_reg.r  <= r5_reg;
        geom_reg.cx <= cx5_reg;
        geom_reg.sx <= sx5_reg;
        geom_reg.cy <= cy_next;
        geom_reg.sy <= sy_next;
    end

    assign geom = geom_reg;

endmodule

// ===== hw/rtl/sdpo_offset.sv =====
// ============================================================================
// sdpo_offset
// Offsets to ball center and highlight, squared and summed over three stages.
// ============================================================================
module sdpo_offset
    import sdpo_pkg::*;
(
    input  logic             clk,
    input  geom_t            geom,
    input  logic [PIX_W-1:0] px,
    input  logic [PIX_W-1:0] py,
    output logic [RAD_W-1:0] center_sq,
    output logic [RAD_W-1:0] spot_sq
);

    logic signed [POS_W-1:0]   dx_reg, dy_reg, ex_reg, ey_reg;
    logic signed [2*POS_W-1:0] dx_sq, dy_sq, ex_sq, ey_sq;
    logic [RAD_W-1:0]          dx2_reg, dy2_reg, ex2_reg, ey2_reg;
    logic [RAD_W-1:0]          center_sq_reg, spot_sq_reg;

    assign dx_sq = dx_reg * dx_reg;
    assign dy_sq = dy_reg * dy_reg;
    assign ex_sq = ex_reg * ex_reg;
    assign ey_sq = ey_reg * ey_reg;

    always_ff @(posedge clk)
    begin
        dx_reg <= $signed({2'b00, geom.cx}) - $signed({2'b00, px});
        dy_reg <= geom.cy - $signed({2'b00, py});
        ex_reg <= $signed({1'b0, geom.sx}) - $signed({2'b00, px});
        ey_reg <= geom.sy - $signed({2'b00, py});

        dx2_reg <= dx_sq[RAD_W-1:0];
        dy2_reg <= dy_sq[RAD_W-1:0];
        ex2_reg <= ex_sq[RAD_W-1:0];
        ey2_reg <= ey_sq[RAD_W-1:0];

        center_sq_reg <= dx2_reg + dy2_reg;
        spot_sq_reg   <= ex2_reg + ey2_reg;
    end

    assign center_sq = center_sq_reg;
    assign spot_sq   = spot_sq_reg;

endmodule

// ===== hw/rtl/sdpo_isqrt.sv =====
// ============================================================================
// sdpo_isqrt
// Floor square root, one result bit per pipeline stage.
// ============================================================================
module sdpo_isqrt
    import sdpo_pkg::*;
(
    input  logic              clk,
    input  logic [RAD_W-1:0]  radicand,
    output logic [ROOT_W-1:0] root
);

    logic [RAD_W-1:0]  rad_reg  [ROOT_W-1];
    logic [ROOT_W:0]   rem_reg  [ROOT_W-1];
    logic [ROOT_W-1:0] root_reg [ROOT_W];

    for (genvar s = 0; s < ROOT_W; s++)
    begin : g_stage
        logic [RAD_W-1:0]  rad_in;
        logic [ROOT_W:0]   rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [ROOT_W+2:0] partial;
        logic [ROOT_W+2:0] trial;
        logic [ROOT_W+2:0] diff;
        logic              fits;
        logic [ROOT_W:0]   rem_next;
        logic [ROOT_W-1:0] root_next;

        if (s == 0)
        begin : g_first
            assign rad_in  = radicand;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign rad_in  = rad_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
        end

        assign partial   = {rem_in, rad_in[RAD_W-1 -: 2]};
        assign trial     = {1'b0, root_in, 2'b01};
        assign diff      = partial - trial;
        assign fits      = (partial >= trial);
        assign rem_next  = fits ? diff[ROOT_W:0] : partial[ROOT_W:0];
        assign root_next = {root_in[ROOT_W-2:0], fits};

        always_ff @(posedge clk)
        begin
            root_reg[s] <= root_next;
        end

        if (s < ROOT_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rad_reg[s] <= {rad_in[RAD_W-3:0], 2'b00};
                rem_reg[s] <= rem_next;
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule
